// ----- rtl/sh4_shift_rotate_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the SH-4 shift and rotate unit
// ----------------------------------------------------------------------------
`ifndef SH4_SHIFT_ROTATE_UNIT_ASSERT_SVH
`define SH4_SHIFT_ROTATE_UNIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante, outside reset.
`define SH4SR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sh4sr same-cycle check failed");

// Check that cons holds in the cycle after ante, outside reset.
`define SH4SR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sh4sr next-cycle check failed");

// Check a property that also spans reset.
`define SH4SR_ASSERT_RESET(label, clk, rst_n, cons) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("sh4sr reset check failed");

`endif

// ----- rtl/sh4sr_pkg.sv -----
// ----------------------------------------------------------------------------
// sh4sr_pkg
// Shared types and constants of the SH-4 shift and rotate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package sh4sr_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned RF_DEPTH    = 16;
  localparam int unsigned RF_AW       = 4;
  localparam int unsigned OP_W        = 4;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned Q_DEPTH     = 2;
  localparam int unsigned Q_AW        = $clog2(Q_DEPTH);
  localparam int unsigned Q_CW        = $clog2(Q_DEPTH + 1);
  localparam logic [DATA_W-1:0] PC_STEP = 32'd2;

  typedef enum logic [OP_W-1:0] {
    OP_ROTL   = 4'd0,
    OP_ROTR   = 4'd1,
    OP_ROTCL  = 4'd2,
    OP_ROTCR  = 4'd3,
    OP_SHAD   = 4'd4,
    OP_SHAR   = 4'd5,
    OP_SHLD   = 4'd6,
    OP_SHLL   = 4'd7,
    OP_SHLR   = 4'd8,
    OP_SHLL2  = 4'd9,
    OP_SHLR2  = 4'd10,
    OP_SHLL8  = 4'd11,
    OP_SHLR8  = 4'd12,
    OP_SHLL16 = 4'd13,
    OP_SHLR16 = 4'd14,
    OP_LOAD   = 4'd15
  } op_t;

  // Decoded instruction as it travels through the queue
  typedef struct packed {
    op_t               op;
    logic [RF_AW-1:0]  rn;
    logic [RF_AW-1:0]  rm;
    logic [DATA_W-1:0] ld;
    logic              upd_t;
  } item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef struct packed {
    logic x_valid;
    logic x_fire;
  } bk_stat_t;

endpackage

`default_nettype wire

// ----- rtl/sh4sr_front.sv -----
// ----------------------------------------------------------------------------
// sh4sr_front
// Accept input words, unpack and classify them for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sh4sr_front (
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [sh4sr_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire sh4sr_pkg::q_stat_t                 q_stat,
  output logic                                    push,
  output sh4sr_pkg::item_t                        item
);

  sh4sr_pkg::op_t op;

  assign op        = sh4sr_pkg::op_t'(in_tdata[3:0]);
  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && in_tready;

  always_comb begin
    item.op = op;
    item.rn = in_tdata[7:4];
    item.rm = in_tdata[11:8];
    item.ld = in_tdata[43:12];
    // flag the single-bit shifts and rotates, which move a bit into T
    unique case (op)
      sh4sr_pkg::OP_ROTL, sh4sr_pkg::OP_ROTR, sh4sr_pkg::OP_ROTCL,
      sh4sr_pkg::OP_ROTCR, sh4sr_pkg::OP_SHAR, sh4sr_pkg::OP_SHLL,
      sh4sr_pkg::OP_SHLR: begin
        item.upd_t = 1'b1;
      end
      default: begin
        item.upd_t = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/sh4sr_queue.sv -----
// ----------------------------------------------------------------------------
// sh4sr_queue
// Short FIFO of decoded instructions between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module sh4sr_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire sh4sr_pkg::item_t      push_item,
  input  wire logic                  pop,
  output sh4sr_pkg::item_t           head,
  output sh4sr_pkg::q_stat_t         stat
);

  sh4sr_pkg::item_t             q_mem_r [sh4sr_pkg::Q_DEPTH];
  logic [sh4sr_pkg::Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [sh4sr_pkg::Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [sh4sr_pkg::Q_CW-1:0]   count_r, count_nxt;

  assign head       = q_mem_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == sh4sr_pkg::Q_CW'(sh4sr_pkg::Q_DEPTH));

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sh4sr_back.sv -----
// ----------------------------------------------------------------------------
// sh4sr_back
// Register file read, shift execute, state update and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sh4sr_back (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire sh4sr_pkg::item_t                    head,
  input  wire sh4sr_pkg::q_stat_t                  q_stat,
  output logic                                     pop,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [sh4sr_pkg::OUT_TDATA_W-1:0]        out_tdata,
  output sh4sr_pkg::bk_stat_t                      stat
);

  localparam int unsigned DW = sh4sr_pkg::DATA_W;

  // register file: no reset on the array, valid bits stand in for zero
  logic [DW-1:0]                  rf_mem_r [sh4sr_pkg::RF_DEPTH];
  logic [sh4sr_pkg::RF_DEPTH-1:0] rf_vld_r;

  // execute stage
  logic                           x_valid_r;
  sh4sr_pkg::op_t                 x_op_r;
  logic [sh4sr_pkg::RF_AW-1:0]    x_rn_r;
  logic [DW-1:0]                  x_ld_r;
  logic                           x_upd_t_r;
  logic [DW-1:0]                  rd_n_r, rd_m_r, fwd_r;
  logic                           byp_n_r, byp_m_r, vld_n_r, vld_m_r;

  // architectural state
  logic                           t_r;
  logic [DW-1:0]                  pc_r, pc_nxt;

  // output register
  logic                           out_valid_r;
  logic [DW-1:0]                  out_res_r;
  logic                           out_t_r;
  logic [DW-1:0]                  out_pc_r;

  logic                           x_adv;
  logic [DW-1:0]                  v, a;
  logic [DW-1:0]                  x_res;
  logic                           t_calc, t_nxt;
  logic [4:0]                     amt;
  logic [5:0]                     rsh;
  logic                           arith;
  logic [DW-1:0]                  dyn_res;

  assign x_adv = x_valid_r && (!out_valid_r || out_tready);
  assign pop   = !q_stat.empty && (!x_valid_r || x_adv);

  // operand select: forward from the retiring instruction, else file or zero
  assign v = byp_n_r ? fwd_r : (vld_n_r ? rd_n_r : '0);
  assign a = byp_m_r ? fwd_r : (vld_m_r ? rd_m_r : '0);

  // dynamic shift: right amount is 32 - Rm[4:0], a full 32 gives fill bits
  assign amt   = a[4:0];
  assign rsh   = 6'd32 - {1'b0, amt};
  assign arith = (x_op_r == sh4sr_pkg::OP_SHAD);

  always_comb begin
    if (!a[DW-1]) begin
      dyn_res = v << amt;
    end else if (arith) begin
      dyn_res = DW'($signed(v) >>> rsh);
    end else begin
      dyn_res = v >> rsh;
    end
  end

  always_comb begin
    t_calc = t_r;
    unique case (x_op_r)
      sh4sr_pkg::OP_ROTL: begin
        t_calc = v[DW-1];
        x_res  = {v[DW-2:0], v[DW-1]};
      end
      sh4sr_pkg::OP_ROTR: begin
        t_calc = v[0];
        x_res  = {v[0], v[DW-1:1]};
      end
      sh4sr_pkg::OP_ROTCL: begin
        t_calc = v[DW-1];
        x_res  = {v[DW-2:0], t_r};
      end
      sh4sr_pkg::OP_ROTCR: begin
        t_calc = v[0];
        x_res  = {t_r, v[DW-1:1]};
      end
      sh4sr_pkg::OP_SHAR: begin
        t_calc = v[0];
        x_res  = {v[DW-1], v[DW-1:1]};
      end
      sh4sr_pkg::OP_SHLL: begin
        t_calc = v[DW-1];
        x_res  = {v[DW-2:0], 1'b0};
      end
      sh4sr_pkg::OP_SHLR: begin
        t_calc = v[0];
        x_res  = {1'b0, v[DW-1:1]};
      end
      sh4sr_pkg::OP_SHAD,
      sh4sr_pkg::OP_SHLD:   x_res = dyn_res;
      sh4sr_pkg::OP_SHLL2:  x_res = v << 2;
      sh4sr_pkg::OP_SHLR2:  x_res = v >> 2;
      sh4sr_pkg::OP_SHLL8:  x_res = v << 8;
      sh4sr_pkg::OP_SHLR8:  x_res = v >> 8;
      sh4sr_pkg::OP_SHLL16: x_res = v << 16;
      sh4sr_pkg::OP_SHLR16: x_res = v >> 16;
      sh4sr_pkg::OP_LOAD:   x_res = x_ld_r;
      default:              x_res = x_ld_r;
    endcase
  end

  assign t_nxt  = x_upd_t_r ? t_calc : t_r;
  assign pc_nxt = pc_r + sh4sr_pkg::PC_STEP;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      rf_vld_r    <= '0;
      t_r         <= 1'b0;
      pc_r        <= '0;
    end else begin
      if (pop) begin
        x_valid_r <= 1'b1;
      end else if (x_adv) begin
        x_valid_r <= 1'b0;
      end
      if (x_adv) begin
        out_valid_r      <= 1'b1;
        rf_vld_r[x_rn_r] <= 1'b1;
        t_r              <= t_nxt;
        pc_r             <= pc_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // register file write and registered reads
  always_ff @(posedge clk) begin
    if (x_adv) begin
      rf_mem_r[x_rn_r] <= x_res;
    end
    if (pop) begin
      rd_n_r <= rf_mem_r[head.rn];
      rd_m_r <= rf_mem_r[head.rm];
    end
  end

  // execute stage payload
  always_ff @(posedge clk) begin
    if (pop) begin
      x_op_r    <= head.op;
      x_rn_r    <= head.rn;
      x_ld_r    <= head.ld;
      x_upd_t_r <= head.upd_t;
      vld_n_r   <= rf_vld_r[head.rn];
      vld_m_r   <= rf_vld_r[head.rm];
      byp_n_r   <= x_adv && (x_rn_r == head.rn);
      byp_m_r   <= x_adv && (x_rn_r == head.rm);
      fwd_r     <= x_res;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (x_adv) begin
      out_res_r <= x_res;
      out_t_r   <= t_nxt;
      out_pc_r  <= pc_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {7'd0, out_pc_r, out_t_r, out_res_r};
  assign stat.x_valid = x_valid_r;
  assign stat.x_fire  = x_adv;

endmodule

`default_nettype wire

// ----- rtl/sh4_shift_rotate_unit.sv -----
// ----------------------------------------------------------------------------
// sh4_shift_rotate_unit - SH-4 shift and rotate instruction executor
// Path: an accepted word goes through queue, execute stage, output register.
// Throughput: one word per cycle unless out_tready stalls the output, set by
// the single execute stage: register file read, shift, write back, forward.
// Reset: synchronous rst_n clears queue, valid bits, T, PC and both valids.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sh4_shift_rotate_unit_assert.svh"

// Structure:
//   front  - unpack in_tdata, mark instructions that update T, push
//   queue  - two-entry FIFO, lets input and execute stall on their own
//   back   - read Rn and Rm (registered), shift, write back, drive output
//
// The register file reads are registered, so an instruction that reads
// the register retired in the same cycle takes the forwarded value.
// Entries never written read as zero through per-entry valid bits.

module sh4_shift_rotate_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [3:0] operation, [7:4] rn, [11:8] rm, [43:12] load_value, [47:44] zero
  input  wire logic [sh4sr_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [31:0] rn_result, [32] t_out, [64:33] next_pc, [71:65] zero
  output logic [sh4sr_pkg::OUT_TDATA_W-1:0]        out_tdata
);

  logic                 push;
  logic                 pop;
  sh4sr_pkg::item_t     push_item;
  sh4sr_pkg::item_t     head;
  sh4sr_pkg::q_stat_t   q_stat;
  sh4sr_pkg::bk_stat_t  bk_stat;

  // accept and classify
  sh4sr_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_stat    (q_stat),
    .push      (push),
    .item      (push_item)
  );

  // hold decoded words until the back end takes them
  sh4sr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // execute and retire
  sh4sr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .stat       (bk_stat)
  );

  // an accepted word is in the queue on the next cycle
  `SH4SR_ASSERT_NEXT(a_push_lands, clk, rst_n, push, !q_stat.empty)
  // a retiring instruction always shows as a result next cycle
  `SH4SR_ASSERT_NEXT(a_retire_shows, clk, rst_n, bk_stat.x_fire, out_tvalid)
  // the back end only pops into a free or draining execute stage
  `SH4SR_ASSERT_SAME(a_pop_room, clk, rst_n, pop && bk_stat.x_valid, bk_stat.x_fire)
  // reset leaves nothing queued and nothing offered
  `SH4SR_ASSERT_RESET(a_reset_idle, clk, rst_n, !out_tvalid && q_stat.empty)

endmodule

`default_nettype wire
